>>> rtl/mspt_pkg.sv
// shared types and constants for the sustain pedal note tracker
package mspt_pkg;

    localparam int NOTES   = 128;
    localparam int HALF    = NOTES / 2;
    localparam int ENTRY_W = 2 * NOTES;

    typedef enum logic [1:0] {
        KIND_ON  = 2'd0,
        KIND_OFF = 2'd1,
        KIND_FWD = 2'd2,
        KIND_REL = 2'd3
    } kind_t;

    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
    localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
    localparam logic [3:0] TYPE_CTRL     = 4'hB;
    localparam logic [6:0] CTRL_SUSTAIN  = 7'd64;
    localparam logic [6:0] PEDAL_ON_MIN  = 7'd64;
    localparam logic [1:0] FULL_LEN      = 2'd3;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [6:0] data_one;
        logic [6:0] data_two;
        logic [1:0] msg_length;
    } msg_t;

    typedef struct packed {
        kind_t           kind;
        logic [3:0]      chan;
        logic [6:0]      note_number;
        logic [6:0]      note_velocity_out;
        logic [7:0]      fwd_status;
        logic [1:0]      fwd_length;
        logic [HALF-1:0] release_low;
        logic [HALF-1:0] release_high;
        logic            last;
    } evt_t;

    typedef struct packed {
        logic               wr_en;
        logic [ENTRY_W-1:0] wr_data;
        logic               pedal_set;
        logic               pedal_clr;
        logic [1:0]         n_res;
    } upd_t;

endpackage

>>> rtl/mspt_ifs.sv
// valid/ready channel interfaces for messages in and events out
interface mspt_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [6:0] data_one;
    logic [6:0] data_two;
    logic [1:0] msg_length;

    modport source (output valid, status_byte, data_one, data_two, msg_length, input ready);
    modport sink (input valid, status_byte, data_one, data_two, msg_length, output ready);
endinterface

interface mspt_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  chan;
    logic [6:0]  note_number;
    logic [6:0]  note_velocity_out;
    logic [7:0]  fwd_status;
    logic [1:0]  fwd_length;
    logic [63:0] release_low;
    logic [63:0] release_high;
    logic        last;

    modport source (output valid, kind, chan, note_number, note_velocity_out, fwd_status,
                    fwd_length, release_low, release_high, last, input ready);
    modport sink (input valid, kind, chan, note_number, note_velocity_out, fwd_status,
                  fwd_length, release_low, release_high, last, output ready);
endinterface

>>> rtl/mspt_ram.sv
// generic single-port-write, registered-read ram
module mspt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read-first: a read at the written address returns the old word
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mspt_note_logic.sv
// per-message decision: new channel entry, pedal update and result events
module mspt_note_logic import mspt_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  msg_t               msg,
    input  logic [ENTRY_W-1:0] entry,
    input  logic               pedal,
    output upd_t               upd,
    output evt_t               evt_a,
    output evt_t               evt_b
);

    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    logic [3:0]       msg_type;
    logic [3:0]       ch;
    logic [NOTES-1:0] snd;
    logic [NOTES-1:0] held;
    logic [NOTES-1:0] mask;
    logic             fwd;
    logic             is_chan;
    evt_t             blank;

    assign msg_type = msg.status_byte[7:4];
    assign ch       = msg.status_byte[3:0];
    assign snd      = entry[NOTES-1:0];
    assign held     = entry[ENTRY_W-1:NOTES];
    assign mask     = NOTES'(1) << msg.data_one;
    assign is_chan  = (msg_type == TYPE_NOTE_OFF) || (msg_type == TYPE_NOTE_ON)
                   || (msg_type == TYPE_CTRL);
    assign fwd      = !is_chan || (msg.msg_length != FULL_LEN) || ({1'b0, ch} >= CH_LIMIT)
                   || ((msg_type == TYPE_CTRL) && (msg.data_one != CTRL_SUSTAIN));

    always_comb
    begin
        blank      = '0;
        blank.kind = KIND_FWD;
        blank.chan = ch;
        upd        = '0;
        evt_a      = blank;
        evt_b      = blank;
        priority if (fwd)
        begin
            upd.n_res               = 2'd1;
            evt_a.kind              = KIND_FWD;
            evt_a.note_number       = msg.data_one;
            evt_a.note_velocity_out = msg.data_two;
            evt_a.fwd_status        = msg.status_byte;
            evt_a.fwd_length        = msg.msg_length;
            evt_a.last              = 1'b1;
        end
        else if (msg_type == TYPE_CTRL)
        begin
            if (msg.data_two >= PEDAL_ON_MIN)
            begin
                upd.pedal_set = 1'b1;
            end
            else
            begin
                // release: drop all held notes of the channel at once
                upd.pedal_clr = 1'b1;
                upd.wr_en     = 1'b1;
                upd.wr_data   = {{NOTES{1'b0}}, snd & ~held};
                if (|held)
                begin
                    upd.n_res          = 2'd1;
                    evt_a.kind         = KIND_REL;
                    evt_a.release_low  = held[HALF-1:0];
                    evt_a.release_high = held[NOTES-1:HALF];
                    evt_a.last         = 1'b1;
                end
            end
        end
        else if ((msg_type == TYPE_NOTE_ON) && (msg.data_two != 7'd0))
        begin
            upd.wr_en   = 1'b1;
            upd.wr_data = {held & ~mask, snd | mask};
            if (snd[msg.data_one])
            begin
                // retrigger: virtual off first, then the on
                upd.n_res               = 2'd2;
                evt_a.kind              = KIND_OFF;
                evt_a.note_number       = msg.data_one;
                evt_b.kind              = KIND_ON;
                evt_b.note_number       = msg.data_one;
                evt_b.note_velocity_out = msg.data_two;
                evt_b.last              = 1'b1;
            end
            else
            begin
                upd.n_res               = 2'd1;
                evt_a.kind              = KIND_ON;
                evt_a.note_number       = msg.data_one;
                evt_a.note_velocity_out = msg.data_two;
                evt_a.last              = 1'b1;
            end
        end
        else
        begin
            if (snd[msg.data_one] && !held[msg.data_one])
            begin
                upd.wr_en = 1'b1;
                if (pedal)
                begin
                    upd.wr_data = {held | mask, snd};
                end
                else
                begin
                    upd.wr_data       = {held, snd & ~mask};
                    upd.n_res         = 2'd1;
                    evt_a.kind        = KIND_OFF;
                    evt_a.note_number = msg.data_one;
                    evt_a.note_velocity_out =
                        (msg_type == TYPE_NOTE_ON) ? 7'd0 : msg.data_two;
                    evt_a.last        = 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/mspt_out_stage.sv
// output register with one pending slot for the second beat of a retrigger
module mspt_out_stage import mspt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [1:0] n_res,
    input  evt_t       evt_a,
    input  evt_t       evt_b,
    output logic       free,
    mspt_evt_if.source evt_out
);

    logic out_valid_reg;
    logic pend_valid_reg;
    evt_t cur_reg;
    evt_t pend_reg;
    logic take;

    assign take = out_valid_reg && evt_out.ready;
    assign free = !out_valid_reg || (take && !pend_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= (n_res == 2'd2);
        end
        else if (take)
        begin
            if (pend_valid_reg)
            begin
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg  <= evt_a;
            pend_reg <= evt_b;
        end
        else if (take && pend_valid_reg)
        begin
            cur_reg <= pend_reg;
        end
    end

    assign evt_out.valid             = out_valid_reg;
    assign evt_out.kind              = cur_reg.kind;
    assign evt_out.chan              = cur_reg.chan;
    assign evt_out.note_number       = cur_reg.note_number;
    assign evt_out.note_velocity_out = cur_reg.note_velocity_out;
    assign evt_out.fwd_status        = cur_reg.fwd_status;
    assign evt_out.fwd_length        = cur_reg.fwd_length;
    assign evt_out.release_low       = cur_reg.release_low;
    assign evt_out.release_high      = cur_reg.release_high;
    assign evt_out.last              = cur_reg.last;

endmodule

>>> rtl/midi_sustain_pedal_note_tracker_core.sv
// sustain pedal note tracker: message in, virtual note events out
//
// msg_in takes one channel message per beat (status, two data bytes, length).
// evt_out gives the resulting events; last marks the final beat of a message.
// Note-on/off and sustain controller 64 update the per-channel note state;
// everything else, and short or out-of-range messages, is forwarded as is.
// Each message is registered in the lookup stage; its events then go to the output register.
// Throughput: one message per cycle while evt_out does not stall and each
// gives at most one event; a retrigger (note-on of a sounding note) gives two events.
// The sounding and held bits of a channel sit in one word of a ram with a
// registered read; a write in the cycle of the next read of the same word
// is forwarded, so there are no bubbles between messages.
// Reset clears the pedal bits and one valid bit per channel word; a word not
// yet written reads as zero, so no clearing pass is needed.
// When evt_out stalls, the finished event waits in the output register, one
// more message waits in the lookup stage, and msg_in.ready then drops.
module midi_sustain_pedal_note_tracker_core import mspt_pkg::*; #(
    parameter int CHANNELS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mspt_msg_if.sink   msg_in,
    mspt_evt_if.source evt_out
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic               accept;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               we;
    logic               byp_hit;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] entry;
    logic               s1_adv;
    logic               out_free;
    upd_t               upd;
    evt_t               evt_a;
    evt_t               evt_b;

    logic                s1_valid_reg;
    msg_t                s1_msg_reg;
    logic                s1_byp_reg;
    logic                s1_vld_reg;
    logic [ENTRY_W-1:0]  s1_byp_data_reg;
    logic [CHANNELS-1:0] ent_valid_reg;
    logic [CHANNELS-1:0] pedal_reg;
    logic [CHANNELS-1:0] ent_valid_next;
    logic [CHANNELS-1:0] pedal_next;

    assign accept        = msg_in.valid && msg_in.ready;
    assign s1_adv        = s1_valid_reg && ((upd.n_res == 2'd0) || out_free);
    assign msg_in.ready  = !s1_valid_reg || s1_adv;
    assign raddr         = msg_in.status_byte[AW-1:0];
    assign waddr         = s1_msg_reg.status_byte[AW-1:0];
    assign we            = s1_adv && upd.wr_en;
    assign byp_hit       = we && (waddr == raddr);

    mspt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (upd.wr_data),
        .re    (accept),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // newest copy of the word: forwarded write, ram data, or zero if never written
    assign entry = s1_byp_reg ? s1_byp_data_reg : (s1_vld_reg ? ram_rdata : '0);

    mspt_note_logic #(
        .CHANNELS (CHANNELS)
    ) u_note_logic (
        .msg   (s1_msg_reg),
        .entry (entry),
        .pedal (pedal_reg[waddr]),
        .upd   (upd),
        .evt_a (evt_a),
        .evt_b (evt_b)
    );

    mspt_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (s1_adv && (upd.n_res != 2'd0)),
        .n_res   (upd.n_res),
        .evt_a   (evt_a),
        .evt_b   (evt_b),
        .free    (out_free),
        .evt_out (evt_out)
    );

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        pedal_next     = pedal_reg;
        if (we)
        begin
            ent_valid_next[waddr] = 1'b1;
        end
        if (s1_adv && upd.pedal_set)
        begin
            pedal_next[waddr] = 1'b1;
        end
        if (s1_adv && upd.pedal_clr)
        begin
            pedal_next[waddr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_byp_reg    <= 1'b0;
            s1_vld_reg    <= 1'b0;
            ent_valid_reg <= '0;
            pedal_reg     <= '0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            pedal_reg     <= pedal_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_byp_reg   <= byp_hit;
                s1_vld_reg   <= ent_valid_reg[raddr];
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_msg_reg.status_byte <= msg_in.status_byte;
            s1_msg_reg.data_one    <= msg_in.data_one;
            s1_msg_reg.data_two    <= msg_in.data_two;
            s1_msg_reg.msg_length  <= msg_in.msg_length;
            s1_byp_data_reg        <= upd.wr_data;
        end
    end

endmodule
